@@ rtl/crc_checked_chunk_deframer_unit_defines.svh @@
// Assertion macros used by the deframer back end.
`ifndef CRC_CHECKED_CHUNK_DEFRAMER_UNIT_DEFINES_SVH
`define CRC_CHECKED_CHUNK_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked by clk_i, off during reset.
`define CCDF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked by clk_i, off during reset.
`define CCDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ccdf_pkg.sv @@
// Types, constants and the CRC byte step of the chunk deframer.
`timescale 1ns / 1ps

package ccdf_pkg;

  localparam int unsigned HeaderBytes  = 16;
  localparam int unsigned TrailerBytes = 4;
  localparam int unsigned CntW         = $clog2(HeaderBytes);
  localparam int unsigned CmdDepth     = 4;
  localparam int unsigned CmdPtrW      = $clog2(CmdDepth);
  localparam int unsigned CmdCntW      = $clog2(CmdDepth + 1);

  localparam logic [31:0] CrcPoly         = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit         = 32'hFFFF_FFFF;
  localparam logic [31:0] MaxPayloadReset = 32'd1048576;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER,
    PH_DISCARD
  } phase_e;

  typedef enum logic [3:0] {
    OP_HDR_BYTE,
    OP_HDR_LAST,
    OP_OVERSIZE,
    OP_PAY_BYTE,
    OP_TRL_BYTE,
    OP_TRL_LAST,
    OP_EOS_CLEAN,
    OP_EOS_TRUNC,
    OP_EOS_DROP
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    RES_HEADER    = 3'd0,
    RES_PAYLOAD   = 3'd1,
    RES_CHUNK_OK  = 3'd2,
    RES_CRC_BAD   = 3'd3,
    RES_TRUNCATED = 3'd4,
    RES_CLEAN_END = 3'd5
  } res_kind_e;

  typedef struct packed {
    res_kind_e   kind;
    logic [31:0] len;
    logic [15:0] ctype;
    logic [15:0] flags;
    logic [63:0] ts;
    logic [7:0]  pbyte;
    logic [31:0] stored;
    logic [31:0] computed;
  } res_t;

  // Advance a reflected CRC-32 by one byte.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/crc_checked_chunk_deframer_unit.sv @@
// Top level of the CRC-checked chunk deframer.
`timescale 1ns / 1ps

// Usage:
//   Input items enter through push/full: an item is taken at a clock edge
//   with push high and full low. kind_i = 0 carries one stream byte in
//   data_byte_i, kind_i = 1 marks the end of the stream.
//   Results leave through empty/pop: while empty is low the oldest result
//   sits on the result ports and is taken at an edge with pop high.
//   cfg_we_i loads max_payload_bytes from cfg_wdata_i; write it while idle.
// Flow and rate:
//   A result is registered once its command leaves the command queue and
//   can be popped at the next edge. The block takes one item per cycle while
//   full is low; the bytewise CRC step in the back end, one byte per cycle,
//   sets that rate. A four-entry command queue separates front and back end.
// Reset:
//   Framing restarts at a header, the queue and result register are empty,
//   and the payload limit returns to 1048576 bytes.
// Stalls:
//   When pop is held low the result register holds, the back end stops and
//   full rises once the queue holds four commands; data items dropped
//   after an oversized header take no queue slot.
module crc_checked_chunk_deframer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic               kind_i,
  input  logic [7:0]         data_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         result_kind_o,
  output logic [31:0]        payload_length_o,
  output logic [15:0]        chunk_type_o,
  output logic [15:0]        chunk_flags_o,
  output logic signed [63:0] timestamp_ns_o,
  output logic [7:0]         payload_byte_o,
  output logic [31:0]        trailer_crc_o,
  output logic [31:0]        calc_crc_o
);

  logic           accept;
  logic           cmd_push;
  ccdf_pkg::cmd_t cmd_in;
  ccdf_pkg::cmd_t cmd_out;
  logic           cmd_empty;
  logic           cmd_pop;
  ccdf_pkg::res_t res;

  assign accept = push && !full;

  ccdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  ccdf_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  ccdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  // Split the result record onto the ports
  assign result_kind_o    = res.kind;
  assign payload_length_o = res.len;
  assign chunk_type_o     = res.ctype;
  assign chunk_flags_o    = res.flags;
  assign timestamp_ns_o   = $signed(res.ts);
  assign payload_byte_o   = res.pbyte;
  assign trailer_crc_o    = res.stored;
  assign calc_crc_o       = res.computed;

endmodule

@@ rtl/ccdf_front.sv @@
// Front end: accepts stream items, tracks chunk framing and issues commands.
`timescale 1ns / 1ps

module ccdf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 accept_i,
  input  logic                 kind_i,
  input  logic [7:0]           data_byte_i,
  output logic                 cmd_push_o,
  output ccdf_pkg::cmd_t       cmd_o
);

  ccdf_pkg::phase_e                phase_q, phase_d;
  logic [ccdf_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [31:0]                     len_q, len_d;
  logic [31:0]                     rem_q, rem_d;
  logic [31:0]                     max_q;
  logic                            hdr_last;
  logic                            trl_last;
  logic                            oversize;
  logic                            gen;

  assign hdr_last = (cnt_q == ccdf_pkg::CntW'(ccdf_pkg::HeaderBytes - 1));
  assign trl_last = (cnt_q == ccdf_pkg::CntW'(ccdf_pkg::TrailerBytes - 1));
  assign oversize = (len_q > max_q);

  // Hold the payload limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= ccdf_pkg::MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // Advance the framing state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    rem_d   = rem_q;
    if (accept_i) begin
      if (kind_i) begin
        phase_d = ccdf_pkg::PH_HEADER;
        cnt_d   = '0;
      end else begin
        case (phase_q)
          ccdf_pkg::PH_HEADER: begin
            cnt_d = cnt_q + 1'b1;
            if (cnt_q < ccdf_pkg::CntW'(4)) begin
              len_d[8*cnt_q[1:0] +: 8] = data_byte_i;
            end
            if (hdr_last) begin
              cnt_d = '0;
              if (oversize) begin
                phase_d = ccdf_pkg::PH_DISCARD;
              end else begin
                rem_d   = len_q;
                phase_d = (len_q != '0) ? ccdf_pkg::PH_PAYLOAD : ccdf_pkg::PH_TRAILER;
              end
            end
          end
          ccdf_pkg::PH_PAYLOAD: begin
            rem_d = rem_q - 1'b1;
            if (rem_q == 32'd1) begin
              phase_d = ccdf_pkg::PH_TRAILER;
              cnt_d   = '0;
            end
          end
          ccdf_pkg::PH_TRAILER: begin
            cnt_d = cnt_q + 1'b1;
            if (trl_last) begin
              phase_d = ccdf_pkg::PH_HEADER;
              cnt_d   = '0;
            end
          end
          default: begin
            phase_d = ccdf_pkg::PH_DISCARD;
          end
        endcase
      end
    end
  end

  // Classify the item into a command
  always_comb begin
    gen       = 1'b1;
    cmd_o.op   = ccdf_pkg::OP_HDR_BYTE;
    cmd_o.data = data_byte_i;
    if (kind_i) begin
      if (phase_q == ccdf_pkg::PH_DISCARD) begin
        cmd_o.op = ccdf_pkg::OP_EOS_DROP;
      end else if (phase_q == ccdf_pkg::PH_HEADER && cnt_q == '0) begin
        cmd_o.op = ccdf_pkg::OP_EOS_CLEAN;
      end else begin
        cmd_o.op = ccdf_pkg::OP_EOS_TRUNC;
      end
    end else begin
      case (phase_q)
        ccdf_pkg::PH_HEADER: begin
          if (hdr_last) begin
            cmd_o.op = oversize ? ccdf_pkg::OP_OVERSIZE : ccdf_pkg::OP_HDR_LAST;
          end
        end
        ccdf_pkg::PH_PAYLOAD: begin
          cmd_o.op = ccdf_pkg::OP_PAY_BYTE;
        end
        ccdf_pkg::PH_TRAILER: begin
          cmd_o.op = trl_last ? ccdf_pkg::OP_TRL_LAST : ccdf_pkg::OP_TRL_BYTE;
        end
        default: begin
          gen = 1'b0;
        end
      endcase
    end
  end

  assign cmd_push_o = accept_i && gen;

  // Update framing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ccdf_pkg::PH_HEADER;
      cnt_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

endmodule

@@ rtl/ccdf_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module ccdf_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ccdf_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output ccdf_pkg::cmd_t data_o,
  output logic           empty_o
);

  ccdf_pkg::cmd_t                mem_q [ccdf_pkg::CmdDepth];
  logic [ccdf_pkg::CmdPtrW-1:0]  wptr_q;
  logic [ccdf_pkg::CmdPtrW-1:0]  rptr_q;
  logic [ccdf_pkg::CmdCntW-1:0]  cnt_q;
  logic                          do_push;
  logic                          do_pop;

  assign full_o  = (cnt_q == ccdf_pkg::CmdCntW'(ccdf_pkg::CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Store commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/ccdf_back.sv @@
// Back end: runs the CRC, collects header and trailer, forms result items.
`timescale 1ns / 1ps
`include "crc_checked_chunk_deframer_unit_defines.svh"

module ccdf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ccdf_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ccdf_pkg::res_t res_o
);

  localparam int unsigned HdrShiftW = 8 * (ccdf_pkg::HeaderBytes - 1);
  localparam int unsigned TrlShiftW = 8 * (ccdf_pkg::TrailerBytes - 1);

  logic [HdrShiftW-1:0] hdr_q;
  logic [TrlShiftW-1:0] trl_q;
  logic [31:0]          crc_q, crc_d;
  logic                 discard_q, discard_d;
  logic                 out_valid_q;
  ccdf_pkg::res_t       res_q, res_d;
  logic                 take;
  logic                 emit;
  logic                 hdr_we;
  logic                 trl_we;
  logic                 is_eos;

  assign take      = !cmd_empty_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = take;
  assign empty_o   = !out_valid_q;
  assign res_o     = res_q;
  assign is_eos    = (cmd_i.op == ccdf_pkg::OP_EOS_CLEAN) ||
                     (cmd_i.op == ccdf_pkg::OP_EOS_TRUNC) ||
                     (cmd_i.op == ccdf_pkg::OP_EOS_DROP);

  // Execute one command
  always_comb begin
    emit      = 1'b0;
    hdr_we    = 1'b0;
    trl_we    = 1'b0;
    crc_d     = crc_q;
    discard_d = discard_q;
    res_d     = '0;
    if (take) begin
      if (discard_q) begin
        if (is_eos) begin
          discard_d = 1'b0;
          crc_d     = ccdf_pkg::CrcInit;
        end
      end else begin
        case (cmd_i.op)
          ccdf_pkg::OP_HDR_BYTE: begin
            hdr_we = 1'b1;
            crc_d  = ccdf_pkg::crc_byte(crc_q, cmd_i.data);
          end
          ccdf_pkg::OP_HDR_LAST: begin
            crc_d       = ccdf_pkg::crc_byte(crc_q, cmd_i.data);
            emit        = 1'b1;
            res_d.kind  = ccdf_pkg::RES_HEADER;
            res_d.len   = hdr_q[31:0];
            res_d.ctype = hdr_q[47:32];
            res_d.flags = hdr_q[63:48];
            res_d.ts    = {cmd_i.data, hdr_q[HdrShiftW-1:64]};
          end
          ccdf_pkg::OP_OVERSIZE: begin
            emit       = 1'b1;
            res_d.kind = ccdf_pkg::RES_TRUNCATED;
            crc_d      = ccdf_pkg::CrcInit;
          end
          ccdf_pkg::OP_PAY_BYTE: begin
            crc_d       = ccdf_pkg::crc_byte(crc_q, cmd_i.data);
            emit        = 1'b1;
            res_d.kind  = ccdf_pkg::RES_PAYLOAD;
            res_d.pbyte = cmd_i.data;
          end
          ccdf_pkg::OP_TRL_BYTE: begin
            trl_we = 1'b1;
          end
          ccdf_pkg::OP_TRL_LAST: begin
            emit           = 1'b1;
            res_d.stored   = {cmd_i.data, trl_q};
            res_d.computed = ~crc_q;
            if ({cmd_i.data, trl_q} == ~crc_q) begin
              res_d.kind = ccdf_pkg::RES_CHUNK_OK;
            end else begin
              res_d.kind = ccdf_pkg::RES_CRC_BAD;
              discard_d  = 1'b1;
            end
            crc_d = ccdf_pkg::CrcInit;
          end
          ccdf_pkg::OP_EOS_CLEAN: begin
            emit       = 1'b1;
            res_d.kind = ccdf_pkg::RES_CLEAN_END;
            crc_d      = ccdf_pkg::CrcInit;
          end
          ccdf_pkg::OP_EOS_TRUNC: begin
            emit       = 1'b1;
            res_d.kind = ccdf_pkg::RES_TRUNCATED;
            crc_d      = ccdf_pkg::CrcInit;
          end
          default: begin
            crc_d = ccdf_pkg::CrcInit;
          end
        endcase
      end
    end
  end

  // Shift in header and trailer bytes
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q <= {cmd_i.data, hdr_q[HdrShiftW-1:8]};
    end
    if (trl_we) begin
      trl_q <= {cmd_i.data, trl_q[TrlShiftW-1:8]};
    end
  end

  // Hold the result until it is popped
  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      res_q <= res_d;
    end
  end

  // Update control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= ccdf_pkg::CrcInit;
      discard_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q     <= crc_d;
      discard_q <= discard_d;
      if (take && emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `CCDF_ASSERT_NEXT(a_mismatch_discards, take && emit && res_d.kind == ccdf_pkg::RES_CRC_BAD, discard_q, "crc mismatch did not enter discard")
  `CCDF_ASSERT_IMPL(a_discard_silent, take && discard_q, !emit, "result formed while discarding")
  `CCDF_ASSERT_NEXT(a_result_kept, out_valid_q && !pop_i, out_valid_q && $stable(res_q), "waiting result overwritten")

endmodule
